/* design/speed_reference_ramp_with_reversal_unit_defines.svh */
// assertion macros for the speed reference ramp unit
`ifndef SPEED_REFERENCE_RAMP_WITH_REVERSAL_UNIT_DEFINES_SVH
`define SPEED_REFERENCE_RAMP_WITH_REVERSAL_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/srr_pkg.sv */
package srr_pkg;

  // field widths
  localparam int ADC_BITS   = 12;
  localparam int SPEED_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int ADDR_W     = 3;
  localparam int ADC_SHIFT  = CFG_W - ADC_BITS;

  typedef logic [SPEED_BITS-1:0] speed_t;
  typedef logic [CFG_W-1:0]      cfg_word_t;
  typedef logic [ADDR_W-1:0]     cfg_addr_t;

  // register indexes
  localparam cfg_addr_t REG_MAX_SPEED      = 3'd0;
  localparam cfg_addr_t REG_MIN_SPEED      = 3'd1;
  localparam cfg_addr_t REG_RAMP_UP_STEP   = 3'd2;
  localparam cfg_addr_t REG_RAMP_DOWN_STEP = 3'd3;
  localparam cfg_addr_t REG_REV_THRESHOLD  = 3'd4;
  localparam cfg_addr_t REG_SETTLE_TICKS   = 3'd5;

  // register reset values
  localparam cfg_word_t RST_MAX_SPEED      = 16'd2300;
  localparam cfg_word_t RST_MIN_SPEED      = 16'd100;
  localparam cfg_word_t RST_RAMP_UP_STEP   = 16'd50;
  localparam cfg_word_t RST_RAMP_DOWN_STEP = 16'd50;
  localparam cfg_word_t RST_REV_THRESHOLD  = 16'd400;
  localparam cfg_word_t RST_SETTLE_TICKS   = 16'd1000;

endpackage

/* design/srr_in_if.sv */
interface srr_in_if import srr_pkg::*;;
  logic                valid;
  logic                ready;
  logic                key_pressed;
  logic                motor_running;
  logic [ADC_BITS-1:0] adc_speed;
  logic [CFG_W-1:0]    measured_speed;
  logic                speed_stable;
  logic                ramp_tick;

  modport source (output valid, key_pressed, motor_running, adc_speed, measured_speed,
                  speed_stable, ramp_tick, input ready);
  modport sink (input valid, key_pressed, motor_running, adc_speed, measured_speed,
                speed_stable, ramp_tick, output ready);
endinterface

/* design/srr_out_if.sv */
interface srr_out_if import srr_pkg::*;;
  logic   valid;
  logic   ready;
  logic   direction_cw;
  logic   stop_request;
  logic   reversal_pending;
  speed_t command_speed;
  speed_t ramp_setpoint;

  modport source (output valid, direction_cw, stop_request, reversal_pending,
                  command_speed, ramp_setpoint, input ready);
  modport sink (input valid, direction_cw, stop_request, reversal_pending,
                command_speed, ramp_setpoint, output ready);
endinterface

/* design/srr_cfg_if.sv */
interface srr_cfg_if import srr_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_word_t wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

/* design/speed_reference_ramp_with_reversal_unit.sv */
// an accepted request is held in the input register, then moves to the result register once it can advance
// throughput: one request per cycle while results are taken, set by the input register and result register pair
// the scaling multiply sits before the input register, key/reversal/ramp logic after it
// reset (rst_n low, synchronous): registers to defaults, direction ccw, no reversal,
// settle count and setpoint zero, both pipeline stages empty
`include "speed_reference_ramp_with_reversal_unit_defines.svh"
module speed_reference_ramp_with_reversal_unit import srr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srr_in_if.sink    in_ch,
  srr_out_if.source out_ch,
  srr_cfg_if.sink   cfg_ch
);

  // configuration registers
  cfg_word_t max_speed_r, min_speed_r, up_step_r, down_step_r, thresh_r, settle_ticks_r;

  // input stage
  logic      s1_valid_r;
  logic      s1_key_r, s1_run_r, s1_stable_r, s1_tick_r;
  speed_t    s1_cmd_r;
  cfg_word_t s1_meas_r;

  // block state
  logic      dir_r, pend_r;
  cfg_word_t settle_r;
  speed_t    sp_r;

  // result stage
  logic      out_valid_r;
  logic      out_dir_r, out_stop_r, out_pend_r;
  speed_t    out_cmd_r, out_sp_r;

  // next values
  logic      dir_nxt, pend_nxt, stop_nxt, pend_k;
  cfg_word_t settle_nxt;
  speed_t    cmd_nxt, sp_nxt, scaled, diff_up, diff_dn;

  logic out_adv, s1_adv, in_rdy;

  assign out_adv = out_ch.ready || !out_valid_r;
  assign s1_adv  = s1_valid_r && out_adv;
  assign in_rdy  = !s1_valid_r || out_adv;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r    <= RST_MAX_SPEED;
      min_speed_r    <= RST_MIN_SPEED;
      up_step_r      <= RST_RAMP_UP_STEP;
      down_step_r    <= RST_RAMP_DOWN_STEP;
      thresh_r       <= RST_REV_THRESHOLD;
      settle_ticks_r <= RST_SETTLE_TICKS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_MAX_SPEED:      max_speed_r    <= cfg_ch.wdata;
        REG_MIN_SPEED:      min_speed_r    <= cfg_ch.wdata;
        REG_RAMP_UP_STEP:   up_step_r      <= cfg_ch.wdata;
        REG_RAMP_DOWN_STEP: down_step_r    <= cfg_ch.wdata;
        REG_REV_THRESHOLD:  thresh_r       <= cfg_ch.wdata;
        REG_SETTLE_TICKS:   settle_ticks_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // adc scaling ahead of the input register
  srr_scale u_scale (
    .adc       (in_ch.adc_speed),
    .max_speed (max_speed_r),
    .min_speed (min_speed_r),
    .cmd       (scaled)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_key_r    <= in_ch.key_pressed;
      s1_run_r    <= in_ch.motor_running;
      s1_cmd_r    <= scaled;
      s1_meas_r   <= in_ch.measured_speed;
      s1_stable_r <= in_ch.speed_stable;
      s1_tick_r   <= in_ch.ramp_tick;
    end
  end

  // key, reversal and settle handling
  always_comb begin
    dir_nxt    = dir_r ^ (s1_key_r && !s1_run_r);
    pend_k     = pend_r || (s1_key_r && s1_run_r);
    pend_nxt   = pend_k;
    stop_nxt   = 1'b0;
    settle_nxt = settle_r;
    cmd_nxt    = '0;
    if (pend_k && (s1_meas_r < thresh_r)) begin
      stop_nxt   = 1'b1;
      dir_nxt    = !dir_nxt;
      pend_nxt   = 1'b0;
      settle_nxt = settle_ticks_r;
    end
    if (!pend_nxt) begin
      if (settle_nxt != '0) begin
        settle_nxt = settle_nxt - cfg_word_t'(1);
      end else begin
        cmd_nxt = s1_cmd_r;
      end
    end
  end

  // setpoint ramp toward the command
  assign diff_up = cmd_nxt - sp_r;
  assign diff_dn = sp_r - cmd_nxt;

  always_comb begin
    sp_nxt = sp_r;
    if (s1_stable_r && s1_tick_r) begin
      if (cmd_nxt > sp_r) begin
        if (CFG_W'(diff_up) > up_step_r) begin
          sp_nxt = sp_r + up_step_r[SPEED_BITS-1:0];
        end else begin
          sp_nxt = cmd_nxt;
        end
      end else if (cmd_nxt < sp_r) begin
        if (CFG_W'(diff_dn) > down_step_r) begin
          sp_nxt = sp_r - down_step_r[SPEED_BITS-1:0];
        end else begin
          sp_nxt = cmd_nxt;
        end
      end
    end
  end

  // block state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      pend_r   <= 1'b0;
      settle_r <= '0;
      sp_r     <= '0;
    end else if (s1_adv) begin
      dir_r    <= dir_nxt;
      pend_r   <= pend_nxt;
      settle_r <= settle_nxt;
      sp_r     <= sp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_dir_r  <= dir_nxt;
      out_stop_r <= stop_nxt;
      out_pend_r <= pend_nxt;
      out_cmd_r  <= cmd_nxt;
      out_sp_r   <= sp_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.direction_cw     = out_dir_r;
  assign out_ch.stop_request     = out_stop_r;
  assign out_ch.reversal_pending = out_pend_r;
  assign out_ch.command_speed    = out_cmd_r;
  assign out_ch.ramp_setpoint    = out_sp_r;

  // checks
  `SRR_ASSERT_NOW(a_stop_clears_pend, out_valid_r && out_stop_r, !out_pend_r,
                  "stop request with reversal still pending")
  `SRR_ASSERT_NOW(a_pend_zero_cmd, out_valid_r && out_pend_r, out_cmd_r == '0,
                  "nonzero command while reversal pending")
  `SRR_ASSERT_NOW(a_cmd_le_max, out_valid_r, CFG_W'(out_cmd_r) <= max_speed_r,
                  "command above max speed")
  `SRR_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_adv, s1_valid_r,
                   "input stage dropped a request under stall")

endmodule

/* design/srr_scale.sv */
module srr_scale import srr_pkg::*; (
  input  logic [ADC_BITS-1:0] adc,
  input  cfg_word_t           max_speed,
  input  cfg_word_t           min_speed,
  output speed_t              cmd
);

  logic [CFG_W-1:0]   left;
  logic [2*CFG_W-1:0] prod;
  speed_t             spd;

  // left-align the reading and scale by full-scale speed
  assign left = CFG_W'(adc) << ADC_SHIFT;
  assign prod = (2*CFG_W)'(left) * (2*CFG_W)'(max_speed);
  assign spd  = prod[CFG_W +: SPEED_BITS];

  // dead band below min, clamp above max
  always_comb begin
    if (CFG_W'(spd) < min_speed) begin
      cmd = '0;
    end else if (CFG_W'(spd) > max_speed) begin
      cmd = max_speed[SPEED_BITS-1:0];
    end else begin
      cmd = spd;
    end
  end

endmodule

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srr_pkg::*;

  // unused register indexes, writes there must be ignored
  localparam cfg_addr_t REG_UNUSED_LO = 3'd6;
  localparam cfg_addr_t REG_UNUSED_HI = 3'd7;

  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 40;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                key;
    logic                running;
    logic [ADC_BITS-1:0] adc;
    speed_t              meas;
    logic                stable;
    logic                tick;
  } tick_req_t;

  typedef struct packed {
    logic   dir_cw;
    logic   stop;
    logic   pending;
    speed_t cmd;
    speed_t setpoint;
  } ramp_res_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  srr_in_if  in_bus();
  srr_out_if out_bus();
  srr_cfg_if cfg_bus();

  speed_reference_ramp_with_reversal_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and model state
  speed_t max_q, min_q, up_q, down_q, thr_q, settle_ticks_q;
  logic   dir_q, pend_q;
  speed_t settle_q, cmd_q, sp_q;

  ramp_res_t expected_ramp_q[$];
  int        mismatches   = 0;
  int        results_seen = 0;

  // sender and receiver control
  int   burst_left    = 0;
  bit   gaps_on       = 1'b1;
  bit   hold_off_req  = 1'b0;

  // one control tick of the speed reference logic
  function automatic ramp_res_t predict_ramp_tick(tick_req_t r);
    ramp_res_t   res;
    logic        stop_now;
    logic [31:0] prod;
    speed_t      scaled;
    stop_now = 1'b0;
    // key: toggle when stopped, start reversal when running
    if (r.key) begin
      if (!r.running) dir_q = ~dir_q;
      else pend_q = 1'b1;
    end
    // pending reversal waits for the speed to fall
    if (pend_q) begin
      cmd_q = '0;
      if (r.meas < thr_q) begin
        stop_now = 1'b1;
        dir_q    = ~dir_q;
        pend_q   = 1'b0;
        settle_q = settle_ticks_q;
      end
    end
    // settle hold or scaled command
    if (!pend_q) begin
      if (settle_q != '0) begin
        settle_q = settle_q - speed_t'(1);
        cmd_q    = '0;
      end else begin
        prod   = {r.adc, {ADC_SHIFT{1'b0}}} * max_q;
        scaled = prod[31:16];
        if (scaled < min_q) scaled = '0;
        if (scaled > max_q) scaled = max_q;
        cmd_q = scaled;
      end
    end
    // rate limited setpoint
    if (r.stable && r.tick) begin
      if (cmd_q > sp_q) begin
        if (cmd_q - sp_q > up_q) sp_q = sp_q + up_q;
        else sp_q = cmd_q;
      end
      if (cmd_q < sp_q) begin
        if (sp_q - cmd_q > down_q) sp_q = sp_q - down_q;
        else sp_q = cmd_q;
      end
    end
    res.dir_cw   = dir_q;
    res.stop     = stop_now;
    res.pending  = pend_q;
    res.cmd      = cmd_q;
    res.setpoint = sp_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch on result %0d: %s expected %0d got %0d",
               $realtime, results_seen, what, exp_v, got_v);
    mismatches++;
  endtask

  // monitor: results first, then register writes, then new requests
  always @(posedge clk) begin : monitor
    ramp_res_t got;
    ramp_res_t exp_r;
    tick_req_t req;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.dir_cw   = out_bus.direction_cw;
        got.stop     = out_bus.stop_request;
        got.pending  = out_bus.reversal_pending;
        got.cmd      = out_bus.command_speed;
        got.setpoint = out_bus.ramp_setpoint;
        results_seen++;
        if (expected_ramp_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, 0);
        end else begin
          exp_r = expected_ramp_q.pop_front();
          if (got.dir_cw !== exp_r.dir_cw)
            report_mismatch("direction_cw", exp_r.dir_cw, got.dir_cw);
          if (got.stop !== exp_r.stop)
            report_mismatch("stop_request", exp_r.stop, got.stop);
          if (got.pending !== exp_r.pending)
            report_mismatch("reversal_pending", exp_r.pending, got.pending);
          if (got.cmd !== exp_r.cmd)
            report_mismatch("command_speed", exp_r.cmd, got.cmd);
          if (got.setpoint !== exp_r.setpoint)
            report_mismatch("ramp_setpoint", exp_r.setpoint, got.setpoint);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.addr)
          REG_MAX_SPEED:      max_q          = cfg_bus.wdata;
          REG_MIN_SPEED:      min_q          = cfg_bus.wdata;
          REG_RAMP_UP_STEP:   up_q           = cfg_bus.wdata;
          REG_RAMP_DOWN_STEP: down_q         = cfg_bus.wdata;
          REG_REV_THRESHOLD:  thr_q          = cfg_bus.wdata;
          REG_SETTLE_TICKS:   settle_ticks_q = cfg_bus.wdata;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        req.key     = in_bus.key_pressed;
        req.running = in_bus.motor_running;
        req.adc     = in_bus.adc_speed;
        req.meas    = in_bus.measured_speed;
        req.stable  = in_bus.speed_stable;
        req.tick    = in_bus.ramp_tick;
        expected_ramp_q.push_back(predict_ramp_tick(req));
      end
    end
  end

  // receiver: stall pattern picked at random for each span, long hold on request
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       phase;
    out_bus.ready = 1'b0;
    phase = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(32, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_bus.ready <= 1'b0;
          for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
          hold_off_req = 1'b0;
          out_bus.ready <= 1'b1;
        end else begin
          phase = (phase + 1) % 3;
          case (mode)
            RX_ALWAYS:      out_bus.ready <= 1'b1;
            RX_COIN:        out_bus.ready <= $urandom_range(0, 1);
            RX_MOSTLY:      out_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_EVERY_THIRD: out_bus.ready <= (phase != 0);
            default:        out_bus.ready <= 1'b1;
          endcase
        end
      end
    end
  end

  // send one request, with random bursts and gaps in between
  task automatic send_tick(tick_req_t r);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_bus.valid          <= 1'b1;
    in_bus.key_pressed    <= r.key;
    in_bus.motor_running  <= r.running;
    in_bus.adc_speed      <= r.adc;
    in_bus.measured_speed <= r.meas;
    in_bus.speed_stable   <= r.stable;
    in_bus.ramp_tick      <= r.tick;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_ramp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_addr_t idx, cfg_word_t val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all_regs(cfg_word_t mx, cfg_word_t mn, cfg_word_t up, cfg_word_t dn,
                                cfg_word_t thr, cfg_word_t settle);
    write_reg(REG_MAX_SPEED, mx);
    write_reg(REG_MIN_SPEED, mn);
    write_reg(REG_RAMP_UP_STEP, up);
    write_reg(REG_RAMP_DOWN_STEP, dn);
    write_reg(REG_REV_THRESHOLD, thr);
    write_reg(REG_SETTLE_TICKS, settle);
  endtask

  function automatic tick_req_t mk(logic key, logic running, logic [ADC_BITS-1:0] adc,
                                   speed_t meas, logic stable, logic tick);
    tick_req_t r;
    r.key     = key;
    r.running = running;
    r.adc     = adc;
    r.meas    = meas;
    r.stable  = stable;
    r.tick    = tick;
    return r;
  endfunction

  // random request biased toward reversal sequences
  function automatic tick_req_t rand_tick();
    tick_req_t r;
    int        sel;
    r.key     = ($urandom_range(0, 11) == 0);
    r.running = ($urandom_range(0, 3) != 0);
    sel = $urandom_range(0, 7);
    if (sel == 0) r.adc = '0;
    else if (sel == 1) r.adc = '1;
    else r.adc = $urandom_range(0, (1 << ADC_BITS) - 1);
    sel = $urandom_range(0, 9);
    if (sel <= 2) r.meas = (thr_q == '0) ? '0 : speed_t'($urandom_range(0, thr_q - 1));
    else if (sel == 3) r.meas = thr_q;
    else if (sel == 4) r.meas = '1;
    else r.meas = $urandom_range(0, 65535);
    r.stable = ($urandom_range(0, 7) != 0);
    r.tick   = $urandom_range(0, 1);
    return r;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_tick(rand_tick());
  endtask

  // scaling, ramp hold and key while stopped, with reset register values
  task automatic test_reset_values();
    send_tick(mk(1'b0, 1'b0, 12'd0,    16'd0,     1'b1, 1'b1));
    send_tick(mk(1'b0, 1'b1, 12'd4095, 16'd65535, 1'b1, 1'b1));
    send_tick(mk(1'b0, 1'b1, 12'd4095, 16'd65535, 1'b0, 1'b1));
    send_tick(mk(1'b0, 1'b1, 12'd4095, 16'd65535, 1'b1, 1'b0));
    send_tick(mk(1'b0, 1'b1, 12'd45,   16'd1000,  1'b1, 1'b1));
    send_tick(mk(1'b1, 1'b0, 12'd2048, 16'd0,     1'b1, 1'b1));
    send_tick(mk(1'b1, 1'b0, 12'd2048, 16'd0,     1'b1, 1'b1));
    drain_results();
  endtask

  // reversal while running, repeated key, key while stopped and pending, settle hold
  task automatic test_reversal_sequences();
    write_all_regs(16'd2300, 16'd100, 16'd65535, 16'd65535, 16'd400, 16'd0);
    send_tick(mk(1'b1, 1'b1, 12'd3000, 16'd5000,  1'b1, 1'b1));
    send_tick(mk(1'b1, 1'b1, 12'd3000, 16'd65535, 1'b1, 1'b1));
    // speed falls: completes, zero settle gives the command at once
    send_tick(mk(1'b0, 1'b1, 12'd3000, 16'd0,     1'b1, 1'b1));
    send_tick(mk(1'b1, 1'b1, 12'd3000, 16'd4000,  1'b1, 1'b1));
    // key while stopped with a reversal waiting
    send_tick(mk(1'b1, 1'b0, 12'd3000, 16'd4000,  1'b1, 1'b1));
    // toggle and completion in the same tick
    send_tick(mk(1'b1, 1'b0, 12'd3000, 16'd10,    1'b1, 1'b1));
    send_tick(mk(1'b0, 1'b0, 12'd4095, 16'd0,     1'b1, 1'b1));
    drain_results();
    write_reg(REG_SETTLE_TICKS, 16'd3);
    // press and completion in one tick, then the settle hold
    send_tick(mk(1'b1, 1'b1, 12'd1000, 16'd399,   1'b1, 1'b1));
    repeat (3) send_tick(mk(1'b0, 1'b1, 12'd1000, 16'd500, 1'b1, 1'b1));
    // threshold boundary: equal speed keeps waiting
    send_tick(mk(1'b1, 1'b1, 12'd1000, 16'd400,   1'b1, 1'b1));
    send_tick(mk(1'b0, 1'b1, 12'd1000, 16'd399,   1'b1, 1'b1));
    repeat (3) send_tick(mk(1'b0, 1'b1, 12'd4095, 16'd0, 1'b1, 1'b1));
    drain_results();
  endtask

  // register extremes, min above max and unused indexes
  task automatic test_register_extremes();
    gaps_on = 1'b1;
    write_all_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random(40);
    drain_results();
    write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    run_random(40);
    drain_results();
    write_all_regs(16'd1000, 16'hFFFF, 16'd1, 16'd1, 16'd1000, 16'd2);
    write_reg(REG_UNUSED_LO, 16'h5A5A);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    run_random(40);
    drain_results();
    write_all_regs(16'd4000, 16'd4000, 16'd300, 16'd7, 16'd2000, 16'd5);
    run_random(40);
    drain_results();
  endtask

  // random register settings with random traffic
  task automatic test_random_traffic();
    cfg_word_t mx, mn, up, dn, thr, settle;
    for (int ph = 0; ph < 8; ph++) begin
      mx     = ($urandom_range(0, 3) == 0) ? 16'hFFFF : cfg_word_t'($urandom_range(0, 65535));
      mn     = ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom_range(0, 65535))
                                           : cfg_word_t'($urandom_range(0, 500));
      up     = ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom_range(0, 65535))
                                           : cfg_word_t'($urandom_range(0, 2000));
      dn     = ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom_range(0, 65535))
                                           : cfg_word_t'($urandom_range(0, 2000));
      thr    = $urandom_range(0, 3000);
      settle = ($urandom_range(0, 4) == 0) ? cfg_word_t'($urandom_range(0, 100))
                                           : cfg_word_t'($urandom_range(0, 10));
      gaps_on = (ph % 3 != 2);
      write_all_regs(mx, mn, up, dn, thr, settle);
      run_random(120);
      drain_results();
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off while requests keep coming, then everything drains
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    run_random(40);
    gaps_on = 1'b1;
    run_random(20);
    drain_results();
  endtask

  // largest settle count, run last since the hold outlasts the test
  task automatic test_long_settle();
    write_all_regs(16'hFFFF, 16'd100, 16'd50, 16'd50, 16'hFFFF, 16'hFFFF);
    send_tick(mk(1'b1, 1'b1, 12'd4095, 16'd100, 1'b1, 1'b1));
    run_random(40);
    drain_results();
  endtask

  // time limit
  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.key_pressed    = 1'b0;
    in_bus.motor_running  = 1'b0;
    in_bus.adc_speed      = '0;
    in_bus.measured_speed = '0;
    in_bus.speed_stable   = 1'b0;
    in_bus.ramp_tick      = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.addr          = REG_MAX_SPEED;
    cfg_bus.wdata         = '0;
    max_q          = RST_MAX_SPEED;
    min_q          = RST_MIN_SPEED;
    up_q           = RST_RAMP_UP_STEP;
    down_q         = RST_RAMP_DOWN_STEP;
    thr_q          = RST_REV_THRESHOLD;
    settle_ticks_q = RST_SETTLE_TICKS;
    dir_q          = 1'b0;
    pend_q         = 1'b0;
    settle_q       = '0;
    cmd_q          = '0;
    sp_q           = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_reversal_sequences();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_long_settle();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_ramp_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
